// ----- hw/rtl/gwb_pkg.sv -----
// Shared constants, weight table, and controller/datapath interface types for the window blur.
`default_nettype none

package gwb_pkg;

  // Widths and channel count fixed by the port list, and the kernel size at reset
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned KS_W      = 4;
  localparam int unsigned KS_RESET  = 3;
  localparam int unsigned NUM_CH    = 4;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_WINDOW_DEF   = 15;
  localparam int unsigned CHANNEL_BITS_DEF = 16;
  localparam int unsigned WEIGHT_BITS_DEF  = 16;

  // exp(-d/2) in Q1.24 for squared distance d = 0..TABLE_LEN-1
  localparam int unsigned TABLE_LEN  = 35;
  localparam int unsigned TABLE_FRAC = 24;
  localparam int unsigned WQ_W       = TABLE_FRAC + 2;

  localparam logic [TABLE_FRAC:0] GAUSS_Q24 [TABLE_LEN] = '{
    25'd16777216, 25'd10175896, 25'd6171993, 25'd3743503, 25'd2270549,
    25'd1377158,  25'd835288,   25'd506628,  25'd307285,  25'd186378,
    25'd113044,   25'd68565,    25'd41587,   25'd25224,   25'd15299,
    25'd9279,     25'd5628,     25'd3414,    25'd2070,    25'd1256,
    25'd762,      25'd462,      25'd280,     25'd170,     25'd103,
    25'd63,       25'd38,       25'd23,      25'd14,      25'd8,
    25'd5,        25'd3,        25'd2,       25'd1,       25'd1
  };

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // take the pixel and its weight, advance the window position
    logic mac;        // add weighted channels and weight into the sums
    logic div_start;  // move the sums into the dividers, clear the sums
    logic div_step;   // one quotient bit per lane
    logic out_load;   // move the quotients into the output register
  } gwb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_pixel; // the current window position is the final pixel
    logic div_done;   // the current divider step is the final one
  } gwb_sts_t;

  // Round half up from Q1.24 to Q0.wb and saturate to the largest code
  function automatic logic [TABLE_FRAC-1:0] gwb_weight(input logic [31:0] sq_dist,
                                                       input int unsigned wb);
    logic [WQ_W-1:0] t2;
    logic [WQ_W-1:0] w;
    logic [WQ_W-1:0] wmax;
    if (sq_dist >= 32'(TABLE_LEN)) begin
      return '0;
    end
    t2   = {GAUSS_Q24[sq_dist[5:0]], 1'b0};
    w    = ((t2 >> (TABLE_FRAC - wb)) + WQ_W'(1)) >> 1;
    wmax = (WQ_W'(1) << wb) - WQ_W'(1);
    if (w > wmax) begin
      w = wmax;
    end
    return w[TABLE_FRAC-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gwb_ctrl.sv -----
// Sequencing state machine for the window blur: pixel capture, accumulate, divide, hand-off.
`default_nettype none

module gwb_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire gwb_pkg::gwb_sts_t sts_i,
  output gwb_pkg::gwb_cmd_t     cmd_o
);
  import gwb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_HOLD  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          last_d        = sts_i.last_pixel;
          state_d       = S_MAC;
        end
      end
      S_MAC: begin
        cmd_o.mac = 1'b1;
        state_d   = last_q ? S_START : S_IDLE;
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_then_mac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> cmd_o.mac)
    else $error("accepted pixel not accumulated in the next cycle");

  a_mid_window_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.mac && !last_q) |=> in_ready_o)
    else $error("not ready for the next pixel inside a window");

  a_start_then_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (cmd_o.div_step && !in_ready_o))
    else $error("divider not stepping after start");

endmodule

`default_nettype wire

// ----- hw/rtl/gwb_dpath.sv -----
// Datapath of the window blur: window position, weight lookup, accumulators, dividers, output.
`default_nettype none

module gwb_dpath #(
  parameter int unsigned MAX_WINDOW   = gwb_pkg::MAX_WINDOW_DEF,
  parameter int unsigned CHANNEL_BITS = gwb_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned WEIGHT_BITS  = gwb_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [gwb_pkg::KS_W-1:0]    cfg_kernel_size_i,
  input  wire logic [gwb_pkg::FIELD_W-1:0] red_in_i,
  input  wire logic [gwb_pkg::FIELD_W-1:0] green_in_i,
  input  wire logic [gwb_pkg::FIELD_W-1:0] blue_in_i,
  input  wire logic [gwb_pkg::FIELD_W-1:0] fourth_in_i,
  input  wire gwb_pkg::gwb_cmd_t           cmd_i,
  output gwb_pkg::gwb_sts_t                sts_o,
  output logic [gwb_pkg::FIELD_W-1:0]      red_out_o,
  output logic [gwb_pkg::FIELD_W-1:0]      green_out_o,
  output logic [gwb_pkg::FIELD_W-1:0]      blue_out_o,
  output logic [gwb_pkg::FIELD_W-1:0]      fourth_out_o
);
  import gwb_pkg::*;

  localparam int unsigned KS_MAX   = (1 << KS_W) - 1;
  localparam int unsigned MAX_SIDE = (MAX_WINDOW < KS_MAX) ? MAX_WINDOW : KS_MAX;
  localparam int unsigned SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int unsigned SQ_W     = 2 * SIDE_W;
  localparam int unsigned D_W      = SQ_W + 1;
  localparam int unsigned CHW      = (CHANNEL_BITS < FIELD_W) ? CHANNEL_BITS : FIELD_W;
  localparam int unsigned WB       = WEIGHT_BITS;
  // Gaussian weights on the grid sum to under 2*pi times the peak, so three guard bits
  localparam int unsigned WT_W     = WB + 3;
  localparam int unsigned ACC_W    = CHW + WT_W;
  localparam int unsigned PROD_W   = CHW + WB;
  localparam int unsigned STEP_W   = $clog2(CHW);

  logic [KS_W-1:0]   ks_q;
  logic [SIDE_W-1:0] col_q, row_q;
  logic [SIDE_W-1:0] side, side_m1, half;
  logic [SIDE_W-1:0] dx, dy;
  logic [SQ_W-1:0]   sq_x, sq_y;
  logic [D_W-1:0]    sq_dist;
  logic [TABLE_FRAC-1:0] w_full;
  logic [WB-1:0]     w_q;
  logic [CHW-1:0]    pix_in [NUM_CH];
  logic [CHW-1:0]    pix_q  [NUM_CH];
  logic [PROD_W-1:0] prod   [NUM_CH];
  logic [ACC_W-1:0]  acc_q  [NUM_CH];
  logic [WT_W-1:0]   wt_q;
  logic [STEP_W-1:0] step_q;
  logic [WT_W-1:0]   dv_q;
  logic [WT_W-1:0]   rem_q  [NUM_CH];
  logic [CHW-1:0]    lo_q   [NUM_CH];
  logic [WT_W:0]     trial  [NUM_CH];
  logic              ge     [NUM_CH];
  logic [WT_W-1:0]   rem_nx [NUM_CH];
  logic [CHW-1:0]    out_q  [NUM_CH];

  assign pix_in[0] = red_in_i[CHW-1:0];
  assign pix_in[1] = green_in_i[CHW-1:0];
  assign pix_in[2] = blue_in_i[CHW-1:0];
  assign pix_in[3] = fourth_in_i[CHW-1:0];

  // Effective side: zero acts as one, oversize clamps to the largest window
  always_comb begin
    if (ks_q == '0) begin
      side = SIDE_W'(1);
    end else if (ks_q > KS_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = ks_q[SIDE_W-1:0];
    end
  end

  assign side_m1 = side - SIDE_W'(1);
  assign half    = side >> 1;
  assign dx      = (col_q >= half) ? (col_q - half) : (half - col_q);
  assign dy      = (row_q >= half) ? (row_q - half) : (half - row_q);
  assign sq_x    = SQ_W'(dx) * SQ_W'(dx);
  assign sq_y    = SQ_W'(dy) * SQ_W'(dy);
  assign sq_dist = D_W'(sq_x) + D_W'(sq_y);
  assign w_full  = gwb_weight(32'(sq_dist), WB);

  assign sts_o.last_pixel = (col_q == side_m1) && (row_q == side_m1);
  assign sts_o.div_done   = (step_q == STEP_W'(CHW - 1));

  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    assign prod[i]   = PROD_W'(w_q) * PROD_W'(pix_q[i]);
    // restoring division, one quotient bit per step
    assign trial[i]  = {rem_q[i], lo_q[i][CHW-1]};
    assign ge[i]     = (trial[i] >= {1'b0, dv_q});
    assign rem_nx[i] = ge[i] ? WT_W'(trial[i] - {1'b0, dv_q}) : trial[i][WT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q   <= KS_W'(KS_RESET);
      col_q  <= '0;
      row_q  <= '0;
      wt_q   <= '0;
      step_q <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        ks_q  <= cfg_kernel_size_i;
        col_q <= '0;
        row_q <= '0;
      end else if (cmd_i.capture) begin
        if (sts_o.last_pixel) begin
          col_q <= '0;
          row_q <= '0;
        end else if (col_q == side_m1) begin
          col_q <= '0;
          row_q <= row_q + SIDE_W'(1);
        end else begin
          col_q <= col_q + SIDE_W'(1);
        end
      end

      if (cfg_valid_i || cmd_i.div_start) begin
        wt_q <= '0;
        for (int i = 0; i < NUM_CH; i++) begin
          acc_q[i] <= '0;
        end
      end else if (cmd_i.mac) begin
        wt_q <= wt_q + WT_W'(w_q);
        for (int i = 0; i < NUM_CH; i++) begin
          acc_q[i] <= acc_q[i] + ACC_W'(prod[i]);
        end
      end

      if (cmd_i.div_start) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      w_q <= w_full[WB-1:0];
      for (int i = 0; i < NUM_CH; i++) begin
        pix_q[i] <= pix_in[i];
      end
    end
    if (cmd_i.div_start) begin
      dv_q <= wt_q;
      for (int i = 0; i < NUM_CH; i++) begin
        rem_q[i] <= acc_q[i][ACC_W-1:CHW];
        lo_q[i]  <= acc_q[i][CHW-1:0];
      end
    end else if (cmd_i.div_step) begin
      for (int i = 0; i < NUM_CH; i++) begin
        rem_q[i] <= rem_nx[i];
        lo_q[i]  <= {lo_q[i][CHW-2:0], ge[i]};
      end
    end
    if (cmd_i.out_load) begin
      for (int i = 0; i < NUM_CH; i++) begin
        out_q[i] <= (dv_q == '0) ? '0 : lo_q[i];
      end
    end
  end

  assign red_out_o    = FIELD_W'(out_q[0]);
  assign green_out_o  = FIELD_W'(out_q[1]);
  assign blue_out_o   = FIELD_W'(out_q[2]);
  assign fourth_out_o = FIELD_W'(out_q[3]);

  a_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> ((rem_q[0] < dv_q) || (dv_q == '0)))
    else $error("divider remainder not below divisor");

  a_sums_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> (wt_q == '0))
    else $error("weight sum not cleared at divider start");

endmodule

`default_nettype wire

// ----- hw/rtl/gaussian_window_blur_unit.sv -----
// Top level of the Gaussian (sigma 1) window blur: handshakes, controller, datapath.
// Each pixel is captured with its weight lookup, then multiply-accumulated before the next is taken.
// After the last pixel of a window: an accumulate, a load into the dividers, one divider step per
//   result bit (CHANNEL_BITS, at most 16), and an output load once the output register is free.
// Pixels are not accepted from the end of a window until its result is loaded; the output register
//   lets the next window start while the result waits.
// Reset: kernel_size returns to 3, window position, sums and output valid are cleared.
`default_nettype none

module gaussian_window_blur_unit #(
  parameter int unsigned MAX_WINDOW   = gwb_pkg::MAX_WINDOW_DEF,
  parameter int unsigned CHANNEL_BITS = gwb_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned WEIGHT_BITS  = gwb_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write channel
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [gwb_pkg::KS_W-1:0]    cfg_kernel_size_i,
  // pixel input channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [gwb_pkg::FIELD_W-1:0] red_in_i,
  input  wire logic [gwb_pkg::FIELD_W-1:0] green_in_i,
  input  wire logic [gwb_pkg::FIELD_W-1:0] blue_in_i,
  input  wire logic [gwb_pkg::FIELD_W-1:0] fourth_in_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [gwb_pkg::FIELD_W-1:0]      red_out_o,
  output logic [gwb_pkg::FIELD_W-1:0]      green_out_o,
  output logic [gwb_pkg::FIELD_W-1:0]      blue_out_o,
  output logic [gwb_pkg::FIELD_W-1:0]      fourth_out_o
);
  import gwb_pkg::*;

  gwb_cmd_t cmd;
  gwb_sts_t sts;

  // A configuration transaction restarts the window, dropping any partial sums,
  // so it is always taken.
  assign cfg_ready_o = 1'b1;

  // Controller: one pixel transaction per IDLE/MAC pair, then at the end of
  // the window a divider run and a hand-off into the output register.
  gwb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: window position and weight table, four weighted-channel sums plus
  // the weight sum, four bit-serial dividers sharing the divisor, output register.
  gwb_dpath #(
    .MAX_WINDOW   (MAX_WINDOW),
    .CHANNEL_BITS (CHANNEL_BITS),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i && cfg_ready_o),
    .cfg_kernel_size_i (cfg_kernel_size_i),
    .red_in_i          (red_in_i),
    .green_in_i        (green_in_i),
    .blue_in_i         (blue_in_i),
    .fourth_in_i       (fourth_in_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .red_out_o         (red_out_o),
    .green_out_o       (green_out_o),
    .blue_out_o        (blue_out_o),
    .fourth_out_o      (fourth_out_o)
  );

endmodule

`default_nettype wire
